// File: rtl/paol_pkg.sv
package paol_pkg;

    localparam int POSITION_SHIFT = 3;
    localparam int SEGMENT_MASK   = 15;
    localparam int STEP_SIZE      = 5;

    localparam int POS_W    = 16;
    localparam int DIFF_W   = 8;
    localparam int ENTRY_W  = 8;
    localparam int SUM_W    = 16;
    localparam int LIMIT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0]   BASE_RESET  = 16'd2100;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_POSITION = 2'd0,
        CFG_ADAPT_LIMIT   = 2'd1
    } t_cfg_index;

    typedef logic signed [ENTRY_W-1:0] t_entry;

endpackage

// File: rtl/position_adaptive_offset_learner.sv
// Position-adaptive offset learner.
// Input channel: i_in_valid with o_in_stall carries one word per door
// position update (i_position, i_difference). Output channel: o_out_valid
// with i_out_stall returns one word per input word (o_learned_offset), the
// stored offset for that position before it is updated.
// Configuration: i_cfg_valid/o_cfg_ready writes base_position (index 0) or
// adapt_limit (index 1); o_cfg_ready is always high. Write only while idle.
// Throughput: one word per cycle while the receiver does not stall. Each
// word does one read of the curve memory at acceptance; a segment-boundary
// word on the curve writes its entry as it leaves the processing stage. A
// write at the same edge as the next read is forwarded to the next word.
// Reset clears the accumulator, loads the register reset values and marks
// every curve entry as unwritten (it reads as zero); no clearing pass is
// needed and the block takes words in the first cycle after reset.
// When the receiver stalls, the output register holds its word, one more
// word waits in the processing stage, and then o_in_stall is raised.
module position_adaptive_offset_learner
    import paol_pkg::*;
#(
    parameter int CURVE_LENGTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [DIFF_W-1:0] i_difference,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [ENTRY_W-1:0] o_learned_offset,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = (CURVE_LENGTH > 1) ? $clog2(CURVE_LENGTH) : 1;

    // Configuration registers.
    logic [POS_W-1:0]   r_base;
    logic [LIMIT_W-1:0] r_limit;

    // Curve memory and per-entry written marks.
    t_entry            mem [CURVE_LENGTH];
    logic [CURVE_LENGTH-1:0] r_vld;

    // Processing stage.
    logic               r_b_valid;
    logic [AW-1:0]      r_b_addr;
    logic               r_b_in_range;
    logic               r_b_seg;
    logic signed [DIFF_W-1:0] r_b_diff;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic               r_fwd_en;
    logic [AW-1:0]      r_fwd_addr;
    t_entry             r_fwd_data;
    logic [SUM_W-1:0]   r_sum;

    // Output register.
    logic               r_out_valid;
    t_entry             r_out_data;

    logic               in_acc;
    logic               b_adv;
    logic               wr_en;
    logic [POS_W-1:0]   pos_off;
    logic [POS_W-1:0]   idx_w;
    logic               in_range;
    logic [AW-1:0]      rd_addr;
    logic               seg;
    t_entry             stored;
    t_entry             entry;
    logic [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0] avg;
    logic signed [SUM_W-1:0] lim16;
    logic signed [SUM_W-1:0] avg_c;
    logic signed [8:0]  avg9;
    logic signed [8:0]  entry9;
    logic signed [8:0]  lim9;
    logic signed [8:0]  upd9;
    logic signed [8:0]  upd_c9;
    t_entry             upd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BASE_POSITION: r_base  <= i_cfg_data;
                CFG_ADAPT_LIMIT:   r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Index selection for the incoming word.
    always_comb begin
        pos_off  = i_position - r_base;
        idx_w    = (i_position > r_base) ? (pos_off >> POSITION_SHIFT) : '0;
        in_range = idx_w < POS_W'(CURVE_LENGTH);
        rd_addr  = idx_w[AW-1:0];
        seg      = (i_position[7:0] & 8'(SEGMENT_MASK)) <= 8'd1;
    end

    assign b_adv      = r_b_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_b_valid && !b_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = b_adv && r_b_seg && r_b_in_range;

    // Read-modify-write of the selected entry.
    always_comb begin
        if (r_fwd_en && (r_fwd_addr == r_b_addr)) begin
            stored = r_fwd_data;
        end else if (r_rd_vld) begin
            stored = r_rd_data;
        end else begin
            stored = '0;
        end
        entry = r_b_in_range ? stored : '0;

        n_sum = r_sum + {{(SUM_W-DIFF_W){r_b_diff[DIFF_W-1]}}, r_b_diff};
        avg   = $signed(n_sum) >>> POSITION_SHIFT;
        lim16 = $signed({{(SUM_W-LIMIT_W){1'b0}}, r_limit});
        if (avg >= lim16) begin
            avg_c = lim16;
        end else if (avg <= -lim16) begin
            avg_c = -lim16;
        end else begin
            avg_c = avg;
        end

        // The clamped average stays within 7 bits plus sign.
        avg9   = avg_c[8:0];
        entry9 = {entry[ENTRY_W-1], entry};
        lim9   = $signed({2'b00, r_limit});
        if (avg9 > entry9) begin
            upd9 = entry9 + 9'sd5;
        end else if ((avg9 < entry9) && (entry9 > 9'sd0)) begin
            upd9 = entry9 - 9'sd5;
        end else begin
            upd9 = entry9;
        end
        if (upd9 >= lim9) begin
            upd_c9 = lim9;
        end else if (upd9 <= -lim9) begin
            upd_c9 = -lim9;
        end else begin
            upd_c9 = upd9;
        end
        upd = upd_c9[ENTRY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_b_addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_b_addr] <= 1'b1;
        end
    end

    // The forward record covers the write that coincides with a read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
        end else if (in_acc) begin
            r_fwd_en <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_addr     <= rd_addr;
            r_b_in_range <= in_range;
            r_b_seg      <= seg;
            r_b_diff     <= i_difference;
            r_rd_vld     <= r_vld[rd_addr];
            r_fwd_addr   <= r_b_addr;
            r_fwd_data   <= upd;
        end
        if (b_adv) begin
            r_out_data <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            if (in_acc) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_out_valid <= 1'b1;
                r_sum       <= r_b_seg ? '0 : n_sum;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_learned_offset = r_out_data;

endmodule

// File: tb/sv/tb.sv
module tb;
    import paol_pkg::*;

    localparam int CURVE_LEN   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 40;

    // Tracks the learned curve and the difference accumulator, and keeps the
    // offsets that the block owes for words it has already taken.
    class offset_scoreboard;
        t_entry             curve [CURVE_LEN];
        logic [SUM_W-1:0]   diff_sum;
        logic [POS_W-1:0]   base;
        logic [LIMIT_W-1:0] limit;
        t_entry             expected_offsets [$];
        int                 errors;

        function new();
            foreach (curve[i]) curve[i] = '0;
            diff_sum = '0;
            base     = BASE_RESET;
            limit    = LIMIT_RESET;
            errors   = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BASE_POSITION)
                base = data[POS_W-1:0];
            else if (idx == CFG_ADAPT_LIMIT)
                limit = data[LIMIT_W-1:0];
        endfunction

        function int clamp(int v);
            int l;
            l = int'(limit);
            if (v >= l)
                return l;
            if (v <= -l)
                return -l;
            return v;
        endfunction

        function void note_word(logic [POS_W-1:0] pos, logic signed [DIFF_W-1:0] diff);
            int idx;
            int entry;
            int avg;
            int upd;
            bit in_range;
            idx = 0;
            if (pos > base)
                idx = int'(pos - base) >> POSITION_SHIFT;
            in_range = idx < CURVE_LEN;
            entry = in_range ? int'(curve[idx]) : 0;
            diff_sum = diff_sum + {{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            if ((int'(pos) & SEGMENT_MASK) <= 1) begin
                avg = clamp(int'($signed(diff_sum)) >>> POSITION_SHIFT);
                upd = entry;
                diff_sum = '0;
                // The entry climbs toward any higher average but only decays while positive.
                if (avg > upd)
                    upd += STEP_SIZE;
                else if (avg < upd && upd > 0)
                    upd -= STEP_SIZE;
                upd = clamp(upd);
                if (in_range)
                    curve[idx] = t_entry'(upd);
            end
            expected_offsets.push_back(t_entry'(entry));
        endfunction

        function void check_word(t_entry actual);
            t_entry want;
            if (expected_offsets.size() == 0) begin
                if (errors < 100)
                    $display("%0t: learned_offset %0d arrived with nothing expected",
                             $time, actual);
                errors++;
                return;
            end
            want = expected_offsets.pop_front();
            if (actual !== want) begin
                if (errors < 100)
                    $display("%0t: learned_offset mismatch: expected %0d, actual %0d",
                             $time, want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_offsets.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [POS_W-1:0]          i_position;
    logic signed [DIFF_W-1:0]  i_difference;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [ENTRY_W-1:0] o_learned_offset;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    offset_scoreboard sb = new();
    bit send_idle_on;
    bit recv_idle_on;
    bit hold_request;
    int cycle_count;

    position_adaptive_offset_learner #(
        .CURVE_LENGTH(CURVE_LEN)
    ) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: checks each word taken at this edge, then picks the stall for
    // the next cycle, including the long hold-off that backs up the block.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall)
                sb.check_word(o_learned_offset);
            if (hold_left != 0)
                hold_left--;
            else if (hold_request) begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 4);
            i_out_stall <= (hold_left != 0);
        end
    end

    task automatic send_word(logic [POS_W-1:0] pos, logic signed [DIFF_W-1:0] diff);
        if (send_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_position   <= pos;
        i_difference <= diff;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_word(pos, diff);
    endtask

    task automatic wait_for_offsets();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        wait_for_offsets();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // A door sweep: positions creep in one direction around the curve while the
    // differences lean one way, so averages build up between segment boundaries.
    task automatic run_sweep(int count);
        logic [POS_W-1:0] pos;
        int start;
        int stride;
        int bias;
        int d;
        bit rising;
        start  = int'(sb.base) + int'($urandom_range(0, 560)) - 24;
        pos    = 16'(start);
        rising = $urandom_range(0, 1);
        bias   = int'($urandom_range(0, 255)) - 128;
        repeat (count) begin
            stride = $urandom_range(0, 3);
            pos = rising ? pos + 16'(stride) : pos - 16'(stride);
            d = bias + int'($urandom_range(0, 40)) - 20;
            if (d > 127)
                d = 127;
            if (d < -128)
                d = -128;
            send_word(pos, 8'(d));
        end
    endtask

    // Long run that never hits a segment boundary, so the accumulator wraps,
    // closed by one boundary word near the curve.
    task automatic run_drift(int count, logic signed [DIFF_W-1:0] d);
        logic [POS_W-1:0] pos;
        int p;
        repeat (count) begin
            pos = 16'($urandom);
            pos[3:0] = 4'($urandom_range(2, 15));
            send_word(pos, d);
        end
        p = int'(sb.base) + int'($urandom_range(0, 500));
        pos = 16'(p);
        pos[3:0] = 4'($urandom_range(0, 1));
        send_word(pos, d);
    endtask

    task automatic run_phase(int items, bit quiet);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            send_idle_on = !quiet && $urandom_range(0, 3) != 0;
            recv_idle_on = !quiet && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(8, 40);
                run_sweep(len);
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) send_word(16'($urandom), 8'($urandom));
            end
            sent += len;
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_position   <= '0;
        i_difference <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_BASE_POSITION;
        i_cfg_data   <= '0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: below the base, exactly at it, first and last entry,
        // just past the curve and far beyond it.
        send_word(16'd0, 8'sd127);
        send_word(16'd0, 8'sd127);
        send_word(16'hFFFF, -8'sd128);
        send_word(16'hFFF0, -8'sd128);
        send_word(16'd2100, 8'sd127);
        send_word(16'd2113, 8'sd127);
        send_word(16'd2113, 8'sd0);
        send_word(16'd2609, 8'sd127);
        send_word(16'd2609, -8'sd128);
        send_word(16'd2624, 8'sd100);
        send_word(16'd2612, 8'sd0);

        // A zero limit pins averages and entries to zero.
        write_reg(CFG_ADAPT_LIMIT, 16'd0);
        send_word(16'd2113, 8'sd127);
        send_word(16'd0, -8'sd128);
        send_word(16'd2113, 8'sd1);

        // Highest base with the full 7-bit limit: every position maps to entry 0.
        write_reg(CFG_BASE_POSITION, 16'hFFFF);
        write_reg(CFG_ADAPT_LIMIT, 16'd127);
        send_word(16'hFFFF, 8'sd127);
        send_word(16'hFFFF, 8'sd127);
        send_word(16'hFFF1, 8'sd127);
        send_word(16'h8000, 8'sd127);

        write_reg(CFG_BASE_POSITION, 16'd0);
        write_reg(CFG_ADAPT_LIMIT, 16'd122);
        send_word(16'd0, -8'sd1);
        send_word(16'd1, 8'sd127);
        send_word(16'd511, 8'sd127);
        send_word(16'd512, -8'sd128);
        send_word(16'h5555, 8'sh55);
        send_word(16'hAAAA, 8'shAA);

        run_phase(240, 1'b0);

        write_reg(CFG_BASE_POSITION, 16'd2100);
        write_reg(CFG_ADAPT_LIMIT, 16'd60);
        hold_request = 1'b1;
        run_phase(240, 1'b0);

        write_reg(CFG_BASE_POSITION, 16'($urandom));
        write_reg(CFG_ADAPT_LIMIT, 16'd127);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        run_drift(280, 8'sd127);
        run_phase(180, 1'b0);

        write_reg(CFG_BASE_POSITION, 16'd65000);
        write_reg(CFG_ADAPT_LIMIT, 16'd1);
        hold_request = 1'b1;
        run_phase(240, 1'b0);

        write_reg(CFG_BASE_POSITION, 16'($urandom));
        write_reg(CFG_ADAPT_LIMIT, 16'($urandom_range(0, 127)));
        run_drift(280, -8'sd128);
        run_phase(180, 1'b0);

        write_reg(CFG_BASE_POSITION, 16'd2100);
        write_reg(CFG_ADAPT_LIMIT, 16'd60);
        run_phase(240, 1'b1);

        wait_for_offsets();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/paol_pkg.sv
rtl/position_adaptive_offset_learner.sv
tb/sv/tb.sv
